### src/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// No dependencies; imported by spq_cell and sorted_priority_queue.
package spq_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_QUEUE_DEPTH   = 16;
    localparam int DEF_PRIORITY_BITS = 16;

    // Fixed field widths on the stream ports
    localparam int PRI_FIELD_W = 16;
    localparam int PAY_W       = 8;
    localparam int CNT_FIELD_W = 5;
    localparam int STATUS_W    = 2;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 32;

    // Command carried on the slave tuser
    typedef enum logic {
        CMD_PUSH = 1'b0,
        CMD_POP  = 1'b1
    } t_cmd;

    // Status carried on the master tuser
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Per-cycle control broadcast to every cell (already qualified)
    typedef struct packed {
        logic push;
        logic pop;
    } t_cell_cmd;

endpackage

### src/sorted_priority_queue.sv
// Top level of the sorted priority queue: a row of spq_cell slots, the
// occupancy counter and the registered result word. Depends on spq_pkg, spq_cell.
//
// Usage:
//   Slave channel takes one command word per accepted beat: tuser selects
//   push (0) or pop (1); tdata carries the entry's priority and payload.
//   Every accepted word yields exactly one result word on the master channel:
//   tuser is the status (ok, push dropped on full, pop on empty), tdata holds
//   the empty flag, the head entry and the entry count after the command.
//   Entries are served in ascending priority; ties go to the larger payload,
//   and a new entry goes ahead of held entries with equal priority and payload.
// Timing:
//   The result word is registered and valid the cycle after accept.
//   Throughput is one word per cycle unless the receiver stalls; every slot compares
//   against the new entry in parallel and shifts by one position in the same cycle.
//   If the receiver stalls, the result register holds and o_s_tready drops
//   until the result is taken; ready returns in the cycle it is taken.
// Reset:
//   Synchronous, active low; the queue comes up empty with no result pending.
module sorted_priority_queue #(
    parameter int QUEUE_DEPTH   = spq_pkg::DEF_QUEUE_DEPTH,
    parameter int PRIORITY_BITS = spq_pkg::DEF_PRIORITY_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Slave side
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [spq_pkg::S_TDATA_W-1:0] i_s_tdata,  // [15:0] entry_priority, [23:16] entry_payload
    input  logic                          i_s_tuser,  // [0] cmd
    // Master side
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [spq_pkg::M_TDATA_W-1:0] o_m_tdata,  // [0] queue_empty, [16:1] head_priority,
                                                      // [24:17] head_payload, [29:25] entry_count
    output logic [spq_pkg::STATUS_W-1:0]  o_m_tuser   // [1:0] status
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Input word fields
    t_cmd                     w_cmd;
    logic [PRIORITY_BITS-1:0] w_new_pri;
    logic [PAY_W-1:0]         w_new_pay;
    logic                     w_accept;
    logic                     w_full;
    logic                     w_empty;
    t_cell_cmd                w_cell_cmd;

    // Cell row wiring
    logic                     w_occ      [QUEUE_DEPTH];
    logic                     w_before   [QUEUE_DEPTH];
    logic                     w_prev_bef [QUEUE_DEPTH];
    logic [PRIORITY_BITS-1:0] w_pri      [QUEUE_DEPTH];
    logic [PAY_W-1:0]         w_pay      [QUEUE_DEPTH];
    logic [PRIORITY_BITS-1:0] w_prev_pri [QUEUE_DEPTH];
    logic [PAY_W-1:0]         w_prev_pay [QUEUE_DEPTH];
    logic [PRIORITY_BITS-1:0] w_next_pri [QUEUE_DEPTH];
    logic [PAY_W-1:0]         w_next_pay [QUEUE_DEPTH];
    logic [PRIORITY_BITS-1:0] w_n_pri    [QUEUE_DEPTH];
    logic [PAY_W-1:0]         w_n_pay    [QUEUE_DEPTH];

    // Control and result registers
    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       n_count;
    logic                   r_valid;
    logic                   n_valid;
    t_status                r_status;
    t_status                n_status;
    logic                   r_empty;
    logic                   n_empty;
    logic [PRI_FIELD_W-1:0] r_head_pri;
    logic [PRI_FIELD_W-1:0] n_head_pri;
    logic [PAY_W-1:0]       r_head_pay;
    logic [PAY_W-1:0]       n_head_pay;
    logic [CNT_FIELD_W-1:0] r_cnt_out;
    logic [CNT_FIELD_W-1:0] n_cnt_out;

    // Unpack the command word; priority bits above PRIORITY_BITS are dropped
    assign w_cmd     = t_cmd'(i_s_tuser);
    assign w_new_pri = PRIORITY_BITS'(i_s_tdata[PRI_FIELD_W-1:0]);
    assign w_new_pay = i_s_tdata[PRI_FIELD_W +: PAY_W];

    assign o_s_tready = !r_valid || i_m_tready;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_full     = (r_count == CNT_W'(QUEUE_DEPTH));
    assign w_empty    = (r_count == '0);

    assign w_cell_cmd.push = w_accept && (w_cmd == CMD_PUSH) && !w_full;
    assign w_cell_cmd.pop  = w_accept && (w_cmd == CMD_POP) && !w_empty;

    // Row of cells, each linked to its neighbors
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        assign w_occ[g] = (CNT_W'(g) < r_count);

        if (g == 0) begin : g_first
            assign w_prev_bef[g] = 1'b0;
            assign w_prev_pri[g] = w_new_pri;
            assign w_prev_pay[g] = w_new_pay;
        end else begin : g_mid
            assign w_prev_bef[g] = w_before[g-1];
            assign w_prev_pri[g] = w_pri[g-1];
            assign w_prev_pay[g] = w_pay[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_last
            assign w_next_pri[g] = w_pri[g];
            assign w_next_pay[g] = w_pay[g];
        end else begin : g_inner
            assign w_next_pri[g] = w_pri[g+1];
            assign w_next_pay[g] = w_pay[g+1];
        end

        spq_cell #(
            .PRIORITY_BITS (PRIORITY_BITS)
        ) u_cell (
            .i_clk         (i_clk),
            .i_cmd         (w_cell_cmd),
            .i_new_pri     (w_new_pri),
            .i_new_pay     (w_new_pay),
            .i_occupied    (w_occ[g]),
            .i_prev_before (w_prev_bef[g]),
            .i_prev_pri    (w_prev_pri[g]),
            .i_prev_pay    (w_prev_pay[g]),
            .i_next_pri    (w_next_pri[g]),
            .i_next_pay    (w_next_pay[g]),
            .o_before      (w_before[g]),
            .o_pri         (w_pri[g]),
            .o_pay         (w_pay[g]),
            .o_n_pri       (w_n_pri[g]),
            .o_n_pay       (w_n_pay[g])
        );
    end

    // Next count, status and result word
    always_comb begin
        n_count    = r_count;
        n_valid    = r_valid;
        n_status   = r_status;
        n_empty    = r_empty;
        n_head_pri = r_head_pri;
        n_head_pay = r_head_pay;
        n_cnt_out  = r_cnt_out;

        if (w_cell_cmd.push) begin
            n_count = r_count + 1'b1;
        end else if (w_cell_cmd.pop) begin
            n_count = r_count - 1'b1;
        end

        if (r_valid && i_m_tready) begin
            n_valid = 1'b0;
        end

        if (w_accept) begin
            n_valid = 1'b1;
            priority if (w_cmd == CMD_PUSH && w_full) begin
                n_status = ST_FULL;
            end else if (w_cmd == CMD_POP && w_empty) begin
                n_status = ST_EMPTY;
            end else begin
                n_status = ST_OK;
            end
            n_empty    = (n_count == '0);
            n_head_pri = n_empty ? '0 : PRI_FIELD_W'(w_n_pri[0]);
            n_head_pay = n_empty ? '0 : w_n_pay[0];
            n_cnt_out  = CNT_FIELD_W'(n_count);
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    // Result payload registers
    always_ff @(posedge i_clk) begin
        r_status   <= n_status;
        r_empty    <= n_empty;
        r_head_pri <= n_head_pri;
        r_head_pay <= n_head_pay;
        r_cnt_out  <= n_cnt_out;
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tuser  = r_status;
    assign o_m_tdata  = {(M_TDATA_W - 1 - PRI_FIELD_W - PAY_W - CNT_FIELD_W)'(0),
                         r_cnt_out, r_head_pay, r_head_pri, r_empty};

    // Occupancy never exceeds the number of cells
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("occupancy above queue depth");

    // A push that fits grows the queue by exactly one
    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && (w_cmd == CMD_PUSH) && !w_full |=>
        r_count == CNT_W'($past(r_count) + 1'b1))
        else $error("push did not grow occupancy");

    // Pending result's empty flag agrees with the occupancy
    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_empty == (r_count == '0)))
        else $error("empty flag disagrees with occupancy");

    // A dropped push is only reported when every cell is used
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && (r_status == ST_FULL) |-> w_full)
        else $error("full status with free cells");

    // First two held entries are in service order
    a_head_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CNT_W'(2)) |->
        ((w_pri[0] < w_pri[1]) || ((w_pri[0] == w_pri[1]) && (w_pay[0] >= w_pay[1]))))
        else $error("head entries out of order");

endmodule

### src/spq_cell.sv
// One slot of the sorted shift-register queue: holds one entry and
// moves it to a neighbor on push or pop. Depends on spq_pkg.
module spq_cell #(
    parameter int PRIORITY_BITS = spq_pkg::DEF_PRIORITY_BITS
) (
    input  logic                      i_clk,
    input  spq_pkg::t_cell_cmd        i_cmd,
    input  logic [PRIORITY_BITS-1:0]  i_new_pri,
    input  logic [spq_pkg::PAY_W-1:0] i_new_pay,
    input  logic                      i_occupied,
    input  logic                      i_prev_before,
    input  logic [PRIORITY_BITS-1:0]  i_prev_pri,
    input  logic [spq_pkg::PAY_W-1:0] i_prev_pay,
    input  logic [PRIORITY_BITS-1:0]  i_next_pri,
    input  logic [spq_pkg::PAY_W-1:0] i_next_pay,
    output logic                      o_before,
    output logic [PRIORITY_BITS-1:0]  o_pri,
    output logic [spq_pkg::PAY_W-1:0] o_pay,
    output logic [PRIORITY_BITS-1:0]  o_n_pri,
    output logic [spq_pkg::PAY_W-1:0] o_n_pay
);
    import spq_pkg::*;

    logic [PRIORITY_BITS-1:0] r_pri;
    logic [PAY_W-1:0]         r_pay;
    logic [PRIORITY_BITS-1:0] n_pri;
    logic [PAY_W-1:0]         n_pay;

    // New word goes ahead of this slot (empty slots always accept)
    assign o_before = !i_occupied || (r_pri > i_new_pri) ||
                      ((r_pri == i_new_pri) && (r_pay <= i_new_pay));

    // Next contents: shift down from the previous slot, insert, or shift up
    always_comb begin
        n_pri = r_pri;
        n_pay = r_pay;
        if (i_cmd.push) begin
            if (i_prev_before) begin
                n_pri = i_prev_pri;
                n_pay = i_prev_pay;
            end else if (o_before) begin
                n_pri = i_new_pri;
                n_pay = i_new_pay;
            end
        end else if (i_cmd.pop) begin
            n_pri = i_next_pri;
            n_pay = i_next_pay;
        end
    end

    // Entry storage, no reset needed
    always_ff @(posedge i_clk) begin
        r_pri <= n_pri;
        r_pay <= n_pay;
    end

    assign o_pri   = r_pri;
    assign o_pay   = r_pay;
    assign o_n_pri = n_pri;
    assign o_n_pay = n_pay;

endmodule
